@@ sv/tcwt_pkg.sv @@
// ---------------------------------------------------------------------------
// tcwt_pkg
// Shared types, constants and helpers of the congestion window tracker.
// ---------------------------------------------------------------------------
`default_nettype none
package tcwt_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int KEY_W         = 32;
    localparam int CNT_W         = 8;
    localparam int LIMIT_W       = 8;
    localparam int WIN_W         = 32;
    localparam int FLAGS_W       = 12;
    localparam int WSIZE_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [WIN_W-1:0]   INIT_SSTHRESH = WIN_W'(8);
    localparam logic [WIN_W-1:0]   WIN_MAX       = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX       = '1;
    localparam int                 FLAG_ACK_BIT  = 4;
    localparam int                 FLAG_SYN_BIT  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DUP_ACK_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRANSMIT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FLOOR     = 2'd2;

    localparam logic [LIMIT_W-1:0] DUP_ACK_LIMIT_RST    = 8'd4;
    localparam logic [LIMIT_W-1:0] RETRANSMIT_LIMIT_RST = 8'd2;
    localparam logic [WSIZE_W-1:0] WINDOW_FLOOR_RST     = 16'd10;

    typedef struct packed {
        logic               start;
        logic               do_count;
        logic               do_check;
        logic [KEY_W-1:0]   key;
        logic [LIMIT_W-1:0] limit;
    } t_tbl_req;

    typedef struct packed {
        logic done;
        logic event_hit;
    } t_tbl_rsp;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_SCAN,
        TBL_UPDATE
    } t_tbl_state;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_OP1,
        TOP_OP2,
        TOP_OP3,
        TOP_FINISH
    } t_top_state;

    function automatic logic [WIN_W-1:0] grow(input logic [WIN_W-1:0] cwnd,
                                              input logic [WIN_W-1:0] ssthresh);
        logic [WIN_W-1:0] res;
        if (cwnd < ssthresh) begin
            res = cwnd[WIN_W-1] ? WIN_MAX : {cwnd[WIN_W-2:0], 1'b0};
        end else begin
            res = (cwnd == WIN_MAX) ? WIN_MAX : cwnd + WIN_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ sv/tcwt_table.sv @@
// ---------------------------------------------------------------------------
// tcwt_table
// Key/count table in a synchronous memory: linear scan, then a
// read-modify-write update for count and threshold check.
// ---------------------------------------------------------------------------
`default_nettype none
module tcwt_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tcwt_pkg::t_tbl_req i_req,
    output tcwt_pkg::t_tbl_rsp     o_rsp
);
    import tcwt_pkg::*;

    localparam int ENT_W = KEY_W + CNT_W;

    logic [ENT_W-1:0]       mem [TABLE_DEPTH];
    logic [ENT_W-1:0]       r_rd_data;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]       r_fill;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_found;
    logic [CNT_W-1:0]       r_hit_cnt;
    logic [KEY_W-1:0]       r_key;
    logic                   r_cnt_en;
    logic                   r_chk_en;
    logic [LIMIT_W-1:0]     r_limit;
    t_tbl_rsp               r_rsp;
    t_tbl_state             r_state, n_state;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   match;
    logic                   last;
    logic                   have;
    logic [IDX_W-1:0]       widx;
    logic [CNT_W-1:0]       cnt1;
    logic                   fire;
    logic [CNT_W-1:0]       cntw;

    assign match = r_valid[r_idx] && (r_rd_data[ENT_W-1:CNT_W] == r_key);
    assign last  = (r_idx == IDX_W'(TABLE_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_idx + IDX_W'(1);
        case (r_state)
            TBL_IDLE: begin
                rd_addr = '0;
                if (i_req.start) begin
                    rd_en   = 1'b1;
                    n_state = TBL_SCAN;
                end
            end
            TBL_SCAN: begin
                if (match || last) begin
                    n_state = TBL_UPDATE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            TBL_UPDATE: n_state = TBL_IDLE;
            default:    n_state = TBL_IDLE;
        endcase
    end

    always_comb begin
        have = 1'b0;
        widx = r_idx;
        cnt1 = r_hit_cnt;
        if (r_found) begin
            have = 1'b1;
            if (r_cnt_en && (r_hit_cnt != CNT_MAX)) begin
                cnt1 = r_hit_cnt + CNT_W'(1);
            end
        end else if (r_cnt_en) begin
            have = 1'b1;
            widx = r_fill;
            cnt1 = CNT_W'(1);
        end
        fire = r_chk_en && have && (cnt1 >= r_limit);
        cntw = fire ? '0 : cnt1;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if ((r_state == TBL_UPDATE) && have) begin
            mem[widx] <= {r_key, cntw};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TBL_IDLE;
            r_valid <= '0;
            r_fill  <= '0;
            r_rsp   <= '0;
        end else begin
            r_state    <= n_state;
            r_rsp.done <= 1'b0;
            if (r_state == TBL_UPDATE) begin
                r_rsp.done      <= 1'b1;
                r_rsp.event_hit <= fire;
                if (!r_found && r_cnt_en) begin
                    r_valid[r_fill] <= 1'b1;
                    r_fill <= (r_fill == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                  : r_fill + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TBL_IDLE: begin
                r_idx    <= '0;
                r_key    <= i_req.key;
                r_cnt_en <= i_req.do_count;
                r_chk_en <= i_req.do_check;
                r_limit  <= i_req.limit;
                r_found  <= 1'b0;
            end
            TBL_SCAN: begin
                if (match) begin
                    r_found   <= 1'b1;
                    r_hit_cnt <= r_rd_data[CNT_W-1:0];
                end else if (!last) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

@@ sv/tcp_congestion_window_tracker_core.sv @@
// ---------------------------------------------------------------------------
// tcp_congestion_window_tracker_core
// Tahoe and Reno window tracker with ack and sequence count tables.
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// s_axis    in         tvalid/tready           tuser: flags, tdata: ack, seq, window
// m_axis    out        tvalid/tready           tuser: event bits, tdata: windows
// cfg       in         we only                 index, data
//
// a table pass runs through start, scan, update and done
// packets without SYN need one pass on both tables at once, SYN packets three
// passes on the seq table, since each memory has one read port
// reset clears valid bits and fill pointers and sets both windows to 1
// a new request is taken while the previous result waits in the output register;
// finish stalls until that register is free
// ---------------------------------------------------------------------------
`default_nettype none
module tcp_congestion_window_tracker_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // ack_number, seq_number, window_size
    input  wire logic [79:0]                        i_s_axis_tdata,
    input  wire logic [tcwt_pkg::FLAGS_W-1:0]       i_s_axis_tuser,  // tcp_flags_in
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tahoe_window, tahoe_threshold, reno_window, reno_threshold
    output logic [127:0]                            o_m_axis_tdata,
    // congestion, dup_ack, retransmit, small_window events
    output logic [3:0]                              o_m_axis_tuser,
    input  wire logic                               i_cfg_we,
    input  wire logic [tcwt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tcwt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tcwt_pkg::*;

    logic [LIMIT_W-1:0] r_dup_limit;
    logic [LIMIT_W-1:0] r_rtx_limit;
    logic [WSIZE_W-1:0] r_win_floor;

    logic [FLAGS_W-1:0] r_flags;
    logic [KEY_W-1:0]   r_ackn;
    logic [KEY_W-1:0]   r_seqn;
    logic [WSIZE_W-1:0] r_wsize;

    logic [WIN_W-1:0]   r_tahoe_cwnd, r_tahoe_ss, r_reno_cwnd, r_reno_ss;
    logic               r_dup_ev, r_rtx_ev;
    logic               r_ack_done, r_seq_done;
    logic               r_out_valid;
    logic [127:0]       r_out_data;
    logic [3:0]         r_out_user;

    t_top_state         r_state, n_state;
    t_tbl_req           ack_req, seq_req;
    t_tbl_rsp           ack_rsp, seq_rsp;

    logic               pure_ack, syn, ack_bit, in_acc, win_ev, any_ev, both_done, out_free;

    assign ack_bit   = r_flags[FLAG_ACK_BIT];
    assign syn       = r_flags[FLAG_SYN_BIT];
    assign pure_ack  = ack_bit && !syn;
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign win_ev    = r_wsize < r_win_floor;
    assign any_ev    = r_dup_ev || r_rtx_ev || win_ev;
    assign both_done = (r_ack_done || ack_rsp.done) && (r_seq_done || seq_rsp.done);
    assign out_free  = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == TOP_IDLE);

    always_comb begin
        n_state = r_state;
        ack_req = '0;
        seq_req = '0;
        ack_req.key   = r_ackn;
        ack_req.limit = r_dup_limit;
        seq_req.key   = r_seqn;
        seq_req.limit = r_rtx_limit;
        case (r_state)
            TOP_IDLE: begin
                if (in_acc) begin
                    n_state = TOP_OP1;
                end
            end
            TOP_OP1: begin
                if (!r_ack_done && !r_seq_done && !ack_rsp.done && !seq_rsp.done) begin
                    ack_req.start    = !both_done;
                end
                ack_req.do_count = pure_ack;
                ack_req.do_check = 1'b1;
                seq_req.do_count = !pure_ack && (r_seqn > KEY_W'(1));
                seq_req.do_check = !syn;
                seq_req.start    = ack_req.start;
                if (both_done) begin
                    n_state = syn ? TOP_OP2 : TOP_FINISH;
                end
            end
            TOP_OP2: begin
                seq_req.key      = r_ackn;
                seq_req.do_count = 1'b1;
                seq_req.start    = !r_seq_done && !seq_rsp.done;
                if (seq_rsp.done) begin
                    n_state = TOP_OP3;
                end
            end
            TOP_OP3: begin
                seq_req.do_check = 1'b1;
                seq_req.start    = !r_seq_done && !seq_rsp.done;
                if (seq_rsp.done) begin
                    n_state = TOP_FINISH;
                end
            end
            TOP_FINISH: begin
                if (out_free) begin
                    n_state = TOP_IDLE;
                end
            end
            default: n_state = TOP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= TOP_IDLE;
            r_dup_limit  <= DUP_ACK_LIMIT_RST;
            r_rtx_limit  <= RETRANSMIT_LIMIT_RST;
            r_win_floor  <= WINDOW_FLOOR_RST;
            r_tahoe_cwnd <= WIN_W'(1);
            r_reno_cwnd  <= WIN_W'(1);
            r_tahoe_ss   <= INIT_SSTHRESH;
            r_reno_ss    <= INIT_SSTHRESH;
            r_out_valid  <= 1'b0;
            r_ack_done   <= 1'b0;
            r_seq_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DUP_ACK_LIMIT:    r_dup_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_RETRANSMIT_LIMIT: r_rtx_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_WINDOW_FLOOR:     r_win_floor <= i_cfg_data[WSIZE_W-1:0];
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (ack_rsp.done) begin
                r_ack_done <= 1'b1;
            end
            if (seq_rsp.done) begin
                r_seq_done <= 1'b1;
            end
            if (((r_state == TOP_OP1) && both_done) ||
                ((r_state == TOP_OP2) && seq_rsp.done) ||
                ((r_state == TOP_OP3) && seq_rsp.done) || (r_state == TOP_IDLE)) begin
                r_ack_done <= 1'b0;
                r_seq_done <= 1'b0;
            end
            if ((r_state == TOP_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
                if (any_ev) begin
                    r_tahoe_ss   <= r_tahoe_cwnd >> 1;
                    r_reno_ss    <= r_reno_cwnd >> 1;
                    r_tahoe_cwnd <= WIN_W'(1);
                    r_reno_cwnd  <= r_reno_cwnd >> 1;
                end else if (ack_bit) begin
                    r_tahoe_cwnd <= grow(r_tahoe_cwnd, r_tahoe_ss);
                    r_reno_cwnd  <= grow(r_reno_cwnd, r_reno_ss);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_flags  <= i_s_axis_tuser;
            r_ackn   <= i_s_axis_tdata[31:0];
            r_seqn   <= i_s_axis_tdata[63:32];
            r_wsize  <= i_s_axis_tdata[79:64];
            r_dup_ev <= 1'b0;
            r_rtx_ev <= 1'b0;
        end
        if (ack_rsp.done && (r_state == TOP_OP1)) begin
            r_dup_ev <= ack_rsp.event_hit;
        end
        if (seq_rsp.done && (((r_state == TOP_OP1) && !syn) || (r_state == TOP_OP3))) begin
            r_rtx_ev <= seq_rsp.event_hit;
        end
        if ((r_state == TOP_FINISH) && out_free) begin
            r_out_data <= {r_reno_ss, r_reno_cwnd, r_tahoe_ss, r_tahoe_cwnd};
            r_out_user <= {win_ev, r_rtx_ev, r_dup_ev, any_ev};
        end
    end

    tcwt_table u_ack_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ack_req),
        .o_rsp   (ack_rsp)
    );

    tcwt_table u_seq_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seq_req),
        .o_rsp   (seq_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire
